[sv/sst_pkg.sv]
// Shared types and constants of the s-expression token scanner.
`default_nettype none

package sst_pkg;

   // Token kinds on the result channel.
   localparam logic [2:0] KIND_OPEN    = 3'd0;
   localparam logic [2:0] KIND_CLOSE   = 3'd1;
   localparam logic [2:0] KIND_INT     = 3'd2;
   localparam logic [2:0] KIND_SYMEND  = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;
   localparam logic [2:0] KIND_SYMCHAR = 3'd5;

   // Character codes the scanner looks for.
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_CASE_OFFSET = 8'h20;

   localparam int unsigned LINE_W = 24;
   localparam logic [LINE_W-1:0] LINE_MAX_COUNT = '1;

   typedef struct packed {
      logic [2:0]        token_kind;
      logic signed [31:0] int_value;
      logic [7:0]        symbol_char;
      logic [LINE_W-1:0] line_number;
      logic              last_result;
   } result_type;

endpackage

`default_nettype wire

[sv/sst_channels_if.sv]
// Valid/ready channel interfaces for the scanner's character input and token output.
`default_nettype none

interface sst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_input;

   modport source (output valid, output char_code, output end_of_input, input ready);
   modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface sst_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         token_kind;
   logic signed [31:0] int_value;
   logic [7:0]         symbol_char;
   logic [23:0]        line_number;
   logic               last_result;

   modport source (output valid, output token_kind, output int_value, output symbol_char,
                   output line_number, output last_result, input ready);
   modport sink (input valid, input token_kind, input int_value, input symbol_char,
                 input line_number, input last_result, output ready);
endinterface

`default_nettype wire

[sv/sexpr_token_scanner_core.sv]
// S-expression token scanner: one character per transfer in, tokens out.
//
// req_port carries one character (or an end-of-input mark) per transfer.
// rsp_port carries tokens: open, close, integer, symbol end, end of input
// and one symbol character for each atom character. A character gives zero,
// one or two tokens; last_result marks the final token of each character.
//
// A transfer on req_port lands in an input register. In the next cycle the
// scan logic updates the atom state and writes its tokens into a result
// queue of QUEUE_DEPTH entries; the queue head drives rsp_port. The first
// token of a character can transfer once it has reached the queue head.
// Characters are taken one per cycle as long as the queue keeps room for
// two more tokens beyond the one still in the input register; while the
// receiver is ready the output side moves one token per cycle, so
// characters that give two tokens drain at that rate.
//
// When the receiver stalls, the queue fills and req_port.ready drops. Reset
// empties the register and the queue, closes any open atom and clears the
// line count.
`default_nettype none

module sexpr_token_scanner_core
   import sst_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sst_req_if.sink    req_port,
   sst_rsp_if.source  rsp_port
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   // Input register.
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_char_ff;
   logic       stage_eoi_ff;

   // Atom and line state.
   logic              in_atom_ff, in_atom_in;
   logic [31:0]       value_ff, value_in;
   logic              negative_ff, negative_in;
   logic              digit_seen_ff, digit_seen_in;
   logic              all_digits_ff, all_digits_in;
   logic [LINE_W-1:0] line_ff, line_in;

   // Result queue.
   result_type       queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W:0]   committed;

   result_type res0, res1, atom_tok;
   logic [1:0] res_count;
   logic       is_sep, is_paren, is_digit, is_sign;
   logic [7:0] lower_char;
   logic       req_fire, rsp_fire;
   logic [1:0] push_count;

   assign req_fire = req_port.valid && req_port.ready;
   assign rsp_fire = rsp_port.valid && rsp_port.ready;

   // Room is reserved for two tokens from a waiting character and two from a new one.
   assign committed = {1'b0, count_ff} + (stage_valid_ff ? (CNT_W + 1)'(2) : '0);
   assign req_port.ready = committed <= (CNT_W + 1)'(QUEUE_DEPTH - 2);
   assign stage_valid_in = req_fire;

   always_comb begin
      is_sep = (stage_char_ff == CHAR_SPACE) || (stage_char_ff == CHAR_NEWLINE) ||
               (stage_char_ff == CHAR_CR) || (stage_char_ff == CHAR_TAB);
      is_paren = (stage_char_ff == CHAR_LPAREN) || (stage_char_ff == CHAR_RPAREN);
      is_digit = (stage_char_ff >= CHAR_ZERO) && (stage_char_ff <= CHAR_NINE);
      is_sign = (stage_char_ff == CHAR_PLUS) || (stage_char_ff == CHAR_MINUS);
      lower_char = ((stage_char_ff >= CHAR_UPPER_A) && (stage_char_ff <= CHAR_UPPER_Z)) ?
                   stage_char_ff + CHAR_CASE_OFFSET : stage_char_ff;

      line_in = line_ff;
      if (stage_valid_ff && !stage_eoi_ff && (stage_char_ff == CHAR_NEWLINE) &&
          (line_ff != LINE_MAX_COUNT)) begin
         line_in = line_ff + LINE_W'(1);
      end

      // Token that closes the current atom.
      atom_tok = '0;
      atom_tok.line_number = line_in;
      if (digit_seen_ff && all_digits_ff) begin
         atom_tok.token_kind = KIND_INT;
         atom_tok.int_value = negative_ff ? -value_ff : value_ff;
      end else begin
         atom_tok.token_kind = KIND_SYMEND;
      end

      res0 = '0;
      res0.line_number = line_in;
      res1 = '0;
      res1.line_number = line_in;
      res_count = 2'd0;
      in_atom_in = in_atom_ff;
      value_in = value_ff;
      negative_in = negative_ff;
      digit_seen_in = digit_seen_ff;
      all_digits_in = all_digits_ff;

      if (stage_valid_ff) begin
         priority if (stage_eoi_ff || is_sep || is_paren) begin
            // Anything that ends an atom; the atom's token comes first.
            if (in_atom_ff) begin
               res0 = atom_tok;
               res_count = 2'd1;
            end
            if (stage_eoi_ff || is_paren) begin
               if (in_atom_ff) begin
                  res1.token_kind = stage_eoi_ff ? KIND_END :
                                    (stage_char_ff == CHAR_LPAREN) ? KIND_OPEN : KIND_CLOSE;
                  res_count = 2'd2;
               end else begin
                  res0.token_kind = stage_eoi_ff ? KIND_END :
                                    (stage_char_ff == CHAR_LPAREN) ? KIND_OPEN : KIND_CLOSE;
                  res_count = 2'd1;
               end
            end
            in_atom_in = 1'b0;
            value_in = '0;
            negative_in = 1'b0;
            digit_seen_in = 1'b0;
            all_digits_in = 1'b1;
         end else begin
            if (!in_atom_ff && is_sign) begin
               negative_in = (stage_char_ff == CHAR_MINUS);
            end else if (is_digit) begin
               value_in = (value_ff << 3) + (value_ff << 1) +
                          32'(stage_char_ff - CHAR_ZERO);
               digit_seen_in = 1'b1;
            end else begin
               all_digits_in = 1'b0;
            end
            in_atom_in = 1'b1;
            res0.token_kind = KIND_SYMCHAR;
            res0.symbol_char = lower_char;
            res_count = 2'd1;
         end
      end

      res0.last_result = (res_count == 2'd1);
      res1.last_result = 1'b1;
   end

   assign push_count = res_count;
   assign count_in = count_ff + CNT_W'(push_count) - (rsp_fire ? CNT_W'(1) : '0);
   assign rd_ptr_in = rsp_fire ? ptr_next(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      unique case (push_count)
         2'd0: wr_ptr_in = wr_ptr_ff;
         2'd1: wr_ptr_in = ptr_next(wr_ptr_ff);
         default: wr_ptr_in = ptr_next(ptr_next(wr_ptr_ff));
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         in_atom_ff <= 1'b0;
         value_ff <= '0;
         negative_ff <= 1'b0;
         digit_seen_ff <= 1'b0;
         all_digits_ff <= 1'b1;
         line_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         in_atom_ff <= in_atom_in;
         value_ff <= value_in;
         negative_ff <= negative_in;
         digit_seen_ff <= digit_seen_in;
         all_digits_ff <= all_digits_in;
         line_ff <= line_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_char_ff <= req_port.char_code;
         stage_eoi_ff <= req_port.end_of_input;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_count == 2'd2) begin
         queue_ff[ptr_next(wr_ptr_ff)] <= res1;
      end
   end

   assign rsp_port.valid = count_ff != '0;
   assign rsp_port.token_kind = queue_ff[rd_ptr_ff].token_kind;
   assign rsp_port.int_value = queue_ff[rd_ptr_ff].int_value;
   assign rsp_port.symbol_char = queue_ff[rd_ptr_ff].symbol_char;
   assign rsp_port.line_number = queue_ff[rd_ptr_ff].line_number;
   assign rsp_port.last_result = queue_ff[rd_ptr_ff].last_result;

endmodule

`default_nettype wire

[sv/sst_checker.sv]
// Port-level checks of the token scanner and their attachment to the top level.
`default_nettype none

module sst_checker
   import sst_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  token_kind,
   input wire logic [31:0] int_value,
   input wire logic [7:0]  symbol_char,
   input wire logic        last_result
);

   // A stalled token stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("token dropped while stalled");

   // A stalled token keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(token_kind) && $stable(int_value) &&
                                  $stable(symbol_char))
      else $error("token changed while stalled");

   // Only integer tokens carry a value and only symbol characters carry a character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (token_kind == KIND_INT || int_value == '0) &&
                    (token_kind == KIND_SYMCHAR || symbol_char == '0))
      else $error("payload field set on wrong token kind");

   // Paren, end and symbol character tokens always finish their character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (token_kind == KIND_OPEN || token_kind == KIND_CLOSE ||
                    token_kind == KIND_END || token_kind == KIND_SYMCHAR) |-> last_result)
      else $error("token that must be last is not marked last");

endmodule

bind sexpr_token_scanner_core sst_checker u_sst_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .token_kind  (rsp_port.token_kind),
   .int_value   (rsp_port.int_value),
   .symbol_char (rsp_port.symbol_char),
   .last_result (rsp_port.last_result)
);

`default_nettype wire
